[rtl/wpcs_pkg.sv]
`timescale 1ns / 1ps

package wpcs_pkg;

   // Input command codes
   typedef enum logic [1:0] {
      CMD_WHEEL   = 2'd0,
      CMD_TICK    = 2'd1,
      CMD_BRAKE   = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   // Configuration register indexes
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_FRONT_LEFT_SETUP  = 3'd0;
   localparam csr_index_type CSR_FRONT_RIGHT_SETUP = 3'd1;
   localparam csr_index_type CSR_REAR_LEFT_SETUP   = 3'd2;
   localparam csr_index_type CSR_REAR_RIGHT_SETUP  = 3'd3;
   localparam csr_index_type CSR_WATCHDOG_ENABLE   = 3'd4;
   localparam csr_index_type CSR_WATCHDOG_TIMEOUT  = 3'd5;

   localparam int SETUP_W   = 36;
   localparam int NUM_WHEEL = 4;

   // Setup word fields
   localparam int MOTOR_LSB  = 0;
   localparam int INVERT_BIT = 3;
   localparam int DB_LSB     = 4;
   localparam int TRIM_LSB   = 20;

   localparam logic [15:0] TRIM_UNITY      = 16'h4000;
   localparam logic [15:0] TIMEOUT_DEFAULT = 16'd500;
   localparam logic [15:0] IDLE_MAX        = 16'hFFFF;

   // Duty arithmetic, in units of 2^-43
   localparam logic [16:0] MAG_MIN      = 17'd164;
   localparam logic [43:0] DUTY_ONE     = 44'h800_0000_0000;
   localparam logic [43:0] DUTY_LOW_MAX = 44'd87960930222;

   // Microcode addresses
   typedef enum logic [3:0] {
      UA_IDLE   = 4'd0,
      UA_A_PWM  = 4'd1,
      UA_A_IN1  = 4'd2,
      UA_A_IN2  = 4'd3,
      UA_W_LOAD = 4'd4,
      UA_W_MUL  = 4'd5,
      UA_W_SUM  = 4'd6,
      UA_W_CNT  = 4'd7,
      UA_D_IN1  = 4'd8,
      UA_D_IN2  = 4'd9,
      UA_D_PWM  = 4'd10,
      UA_W_NEXT = 4'd11,
      UA_O_PWM  = 4'd12,
      UA_O_IN1  = 4'd13,
      UA_O_IN2  = 4'd14
   } uaddr_type;

   typedef enum logic [1:0] {
      CH_PWM = 2'd0,
      CH_IN1 = 2'd1,
      CH_IN2 = 2'd2
   } chsel_type;

   typedef enum logic [1:0] {
      WR_OFF     = 2'd0,
      WR_DIR_IN1 = 2'd1,
      WR_DIR_IN2 = 2'd2,
      WR_PWM     = 2'd3
   } wrsel_type;

   typedef enum logic [1:0] {
      LAST_NONE  = 2'd0,
      LAST_MOTOR = 2'd1,
      LAST_WHEEL = 2'd2
   } lastsel_type;

   typedef enum logic [2:0] {
      DP_NONE = 3'd0,
      DP_LOAD = 3'd1,
      DP_MUL  = 3'd2,
      DP_SUM  = 3'd3,
      DP_CNT  = 3'd4
   } dpop_type;

   typedef enum logic [2:0] {
      JC_NONE        = 3'd0,
      JC_UNMAPPED    = 3'd1,
      JC_LOW_DUTY    = 3'd2,
      JC_MORE_MOTORS = 3'd3,
      JC_MORE_WHEELS = 3'd4
   } cond_type;

   typedef struct packed {
      logic        emit;
      chsel_type   ch;
      wrsel_type   wr;
      lastsel_type lst;
      dpop_type    op;
      cond_type    cond;
      logic        adv_motor;
      logic        adv_wheel;
      uaddr_type   tgt_t;
      uaddr_type   tgt_f;
   } uword_type;

   // Build one control word
   function automatic uword_type uw(logic emit, chsel_type ch, wrsel_type wr,
                                    lastsel_type lst, dpop_type op, cond_type cond,
                                    logic adv_motor, logic adv_wheel,
                                    uaddr_type tgt_t, uaddr_type tgt_f);
      uword_type w;
      w.emit      = emit;
      w.ch        = ch;
      w.wr        = wr;
      w.lst       = lst;
      w.op        = op;
      w.cond      = cond;
      w.adv_motor = adv_motor;
      w.adv_wheel = adv_wheel;
      w.tgt_t     = tgt_t;
      w.tgt_f     = tgt_f;
      return w;
   endfunction

   // Control store: all-motors-off loop, then the per-wheel program
   function automatic uword_type ucode_rom(uaddr_type a);
      uword_type w;
      case (a)
         UA_A_PWM:  w = uw(1'b1, CH_PWM, WR_OFF, LAST_NONE, DP_NONE, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_A_IN1);
         UA_A_IN1:  w = uw(1'b1, CH_IN1, WR_OFF, LAST_NONE, DP_NONE, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_A_IN2);
         UA_A_IN2:  w = uw(1'b1, CH_IN2, WR_OFF, LAST_MOTOR, DP_NONE, JC_MORE_MOTORS,
                           1'b1, 1'b0, UA_A_PWM, UA_IDLE);
         UA_W_LOAD: w = uw(1'b0, CH_PWM, WR_OFF, LAST_NONE, DP_LOAD, JC_UNMAPPED,
                           1'b0, 1'b0, UA_W_NEXT, UA_W_MUL);
         UA_W_MUL:  w = uw(1'b0, CH_PWM, WR_OFF, LAST_NONE, DP_MUL, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_W_SUM);
         UA_W_SUM:  w = uw(1'b0, CH_PWM, WR_OFF, LAST_NONE, DP_SUM, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_W_CNT);
         UA_W_CNT:  w = uw(1'b0, CH_PWM, WR_OFF, LAST_NONE, DP_CNT, JC_LOW_DUTY,
                           1'b0, 1'b0, UA_O_PWM, UA_D_IN1);
         UA_D_IN1:  w = uw(1'b1, CH_IN1, WR_DIR_IN1, LAST_NONE, DP_NONE, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_D_IN2);
         UA_D_IN2:  w = uw(1'b1, CH_IN2, WR_DIR_IN2, LAST_NONE, DP_NONE, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_D_PWM);
         UA_D_PWM:  w = uw(1'b1, CH_PWM, WR_PWM, LAST_WHEEL, DP_NONE, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_W_NEXT);
         UA_W_NEXT: w = uw(1'b0, CH_PWM, WR_OFF, LAST_NONE, DP_NONE, JC_MORE_WHEELS,
                           1'b0, 1'b1, UA_W_LOAD, UA_IDLE);
         UA_O_PWM:  w = uw(1'b1, CH_PWM, WR_OFF, LAST_NONE, DP_NONE, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_O_IN1);
         UA_O_IN1:  w = uw(1'b1, CH_IN1, WR_OFF, LAST_NONE, DP_NONE, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_O_IN2);
         UA_O_IN2:  w = uw(1'b1, CH_IN2, WR_OFF, LAST_WHEEL, DP_NONE, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_W_NEXT);
         default:   w = uw(1'b0, CH_PWM, WR_OFF, LAST_NONE, DP_NONE, JC_NONE,
                           1'b0, 1'b0, UA_IDLE, UA_IDLE);
      endcase
      return w;
   endfunction

   // Motor channel map; motor index is motor number minus one
   function automatic logic [3:0] motor_channel(logic [1:0] m, chsel_type ch);
      logic [3:0] c;
      case (ch)
         CH_PWM: begin
            case (m)
               2'd0:    c = 4'd8;
               2'd1:    c = 4'd13;
               2'd2:    c = 4'd2;
               default: c = 4'd7;
            endcase
         end
         CH_IN1: begin
            case (m)
               2'd0:    c = 4'd10;
               2'd1:    c = 4'd11;
               2'd2:    c = 4'd4;
               default: c = 4'd5;
            endcase
         end
         default: begin
            case (m)
               2'd0:    c = 4'd9;
               2'd1:    c = 4'd12;
               2'd2:    c = 4'd3;
               default: c = 4'd6;
            endcase
         end
      endcase
      return c;
   endfunction

endpackage

[rtl/wpcs_req_if.sv]
`timescale 1ns / 1ps

interface wpcs_req_if;
   logic                valid;
   logic                ready;
   wpcs_pkg::cmd_type   cmd;
   logic signed [15:0]  front_left_speed;
   logic signed [15:0]  front_right_speed;
   logic signed [15:0]  rear_left_speed;
   logic signed [15:0]  rear_right_speed;

   modport source (
      output valid, cmd, front_left_speed, front_right_speed,
             rear_left_speed, rear_right_speed,
      input  ready
   );
   modport sink (
      input  valid, cmd, front_left_speed, front_right_speed,
             rear_left_speed, rear_right_speed,
      output ready
   );
endinterface

[rtl/wpcs_rsp_if.sv]
`timescale 1ns / 1ps

interface wpcs_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  channel;
   logic        full_on;
   logic        full_off;
   logic [11:0] off_point;
   logic        last;

   modport source (
      output valid, channel, full_on, full_off, off_point, last,
      input  ready
   );
   modport sink (
      input  valid, channel, full_on, full_off, off_point, last,
      output ready
   );
endinterface

[rtl/wheel_pwm_command_sequencer.sv]
`timescale 1ns / 1ps
// A brake or a tripping tick starts the all-motors-off loop, 12 write steps; a wheel command
// runs 8 steps per mapped wheel (load, multiply, sum, count, three writes, next) and 2 per
// unmapped one (load, next), so its first write waits on those steps. Other and ignored
// commands run no steps. A new command beat is taken only once the program is idle again.
// Writes leave through the output register; output stalls hold the sequencer in place.
// Reset (synchronous): register defaults restored, latches and counters cleared, idle.
module wheel_pwm_command_sequencer (
   input  logic                      clock,
   input  logic                      reset,
   wpcs_req_if.sink                  req,
   wpcs_rsp_if.source                rsp,
   input  logic                      csr_we,
   input  wpcs_pkg::csr_index_type   csr_index,
   input  logic [35:0]               csr_wdata
);

   // Configuration registers
   logic [35:0] setup_ff [wpcs_pkg::NUM_WHEEL];
   logic        wd_enable_ff;
   logic [15:0] wd_timeout_ff;

   // Command state
   logic        stop_ff, stop_in;
   logic        fired_ff, fired_in;
   logic [15:0] idle_ff, idle_in;

   // Sequencer
   wpcs_pkg::uaddr_type pc_ff, pc_in, entry;
   wpcs_pkg::uword_type cw;
   logic [1:0]  mot_ff, mot_in;
   logic [1:0]  wheel_ff, wheel_in;
   logic        req_fire, step_go, out_free, cond_hit, start_off, start_wheel;

   // Datapath
   logic [15:0]        speed_ff [wpcs_pkg::NUM_WHEEL];
   logic               fwd_ff;
   logic               small_ff;
   logic [15:0]        db_ff;
   logic [32:0]        p1_ff;
   logic signed [51:0] p2_ff;
   logic [43:0]        duty_ff;
   logic [11:0]        cnt_ff;
   logic               full_ff;

   logic [35:0]        cur_setup;
   logic [15:0]        cur_speed;
   logic [16:0]        mag;
   logic signed [17:0] db_rest;
   logic signed [52:0] sum;
   logic [55:0]        scaled;
   logic [3:0]         mapped;
   logic               wheels_above;
   logic               low_duty;

   // Output register
   logic        rsp_valid_ff;
   logic [3:0]  rsp_channel_ff;
   logic        rsp_full_on_ff;
   logic        rsp_full_off_ff;
   logic [11:0] rsp_off_point_ff;
   logic        rsp_last_ff;
   logic        wr_on, wr_off, wr_last;
   logic [11:0] wr_cnt;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < wpcs_pkg::NUM_WHEEL; i++) begin
            setup_ff[i] <= {wpcs_pkg::TRIM_UNITY, 16'd0, 1'b0, 3'(i + 1)};
         end
         wd_enable_ff  <= 1'b1;
         wd_timeout_ff <= wpcs_pkg::TIMEOUT_DEFAULT;
      end else if (csr_we) begin
         case (csr_index)
            wpcs_pkg::CSR_FRONT_LEFT_SETUP:  setup_ff[0] <= csr_wdata;
            wpcs_pkg::CSR_FRONT_RIGHT_SETUP: setup_ff[1] <= csr_wdata;
            wpcs_pkg::CSR_REAR_LEFT_SETUP:   setup_ff[2] <= csr_wdata;
            wpcs_pkg::CSR_REAR_RIGHT_SETUP:  setup_ff[3] <= csr_wdata;
            wpcs_pkg::CSR_WATCHDOG_ENABLE:   wd_enable_ff <= csr_wdata[0];
            wpcs_pkg::CSR_WATCHDOG_TIMEOUT:  wd_timeout_ff <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign req.ready = (pc_ff == wpcs_pkg::UA_IDLE);
   assign req_fire  = req.valid && req.ready;

   // Decode the accepted command: update latches, pick the program entry
   always_comb begin
      logic [15:0] idle_inc;
      idle_inc    = (idle_ff == wpcs_pkg::IDLE_MAX) ? idle_ff : idle_ff + 16'd1;
      stop_in     = stop_ff;
      fired_in    = fired_ff;
      idle_in     = idle_ff;
      entry       = wpcs_pkg::UA_IDLE;
      start_off   = 1'b0;
      start_wheel = 1'b0;
      if (req_fire) begin
         case (req.cmd)
            wpcs_pkg::CMD_WHEEL: begin
               if (!stop_ff) begin
                  idle_in     = 16'd0;
                  fired_in    = 1'b0;
                  entry       = wpcs_pkg::UA_W_LOAD;
                  start_wheel = 1'b1;
               end
            end
            wpcs_pkg::CMD_TICK: begin
               idle_in = idle_inc;
               if (wd_enable_ff && !stop_ff && !fired_ff && idle_inc > wd_timeout_ff) begin
                  fired_in  = 1'b1;
                  entry     = wpcs_pkg::UA_A_PWM;
                  start_off = 1'b1;
               end
            end
            wpcs_pkg::CMD_BRAKE: begin
               stop_in   = 1'b1;
               entry     = wpcs_pkg::UA_A_PWM;
               start_off = 1'b1;
            end
            default: begin
               stop_in  = 1'b0;
               fired_in = 1'b0;
               idle_in  = 16'd0;
            end
         endcase
      end
   end

   // Control word and step conditions
   always_comb begin
      cw        = wpcs_pkg::ucode_rom(pc_ff);
      out_free  = !rsp_valid_ff || rsp.ready;
      step_go   = !cw.emit || out_free;
      for (int i = 0; i < wpcs_pkg::NUM_WHEEL; i++) begin
         mapped[i] = setup_ff[i][2:0] inside {[3'd1:3'd4]};
      end
      wheels_above = 1'b0;
      for (int i = 0; i < wpcs_pkg::NUM_WHEEL; i++) begin
         if (mapped[i] && (2'(i) > wheel_ff)) wheels_above = 1'b1;
      end
      low_duty = (duty_ff <= wpcs_pkg::DUTY_LOW_MAX);
      case (cw.cond)
         wpcs_pkg::JC_UNMAPPED:    cond_hit = !mapped[wheel_ff];
         wpcs_pkg::JC_LOW_DUTY:    cond_hit = low_duty;
         wpcs_pkg::JC_MORE_MOTORS: cond_hit = (mot_ff != 2'd3);
         wpcs_pkg::JC_MORE_WHEELS: cond_hit = (wheel_ff != 2'd3);
         default:                  cond_hit = 1'b0;
      endcase
   end

   // Next step address
   always_comb begin
      pc_in = pc_ff;
      if (pc_ff == wpcs_pkg::UA_IDLE) begin
         pc_in = entry;
      end else if (step_go) begin
         pc_in = cond_hit ? cw.tgt_t : cw.tgt_f;
      end
   end

   // Motor and wheel counters
   always_comb begin
      mot_in   = mot_ff;
      wheel_in = wheel_ff;
      if (start_off) mot_in = 2'd0;
      if (start_wheel) wheel_in = 2'd0;
      if (step_go && cw.op == wpcs_pkg::DP_LOAD) begin
         mot_in = 2'(cur_setup[2:0] - 3'd1);
      end
      if (step_go && cw.adv_motor) mot_in = mot_ff + 2'd1;
      if (step_go && cw.adv_wheel) wheel_in = wheel_ff + 2'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff    <= wpcs_pkg::UA_IDLE;
         stop_ff  <= 1'b0;
         fired_ff <= 1'b0;
         idle_ff  <= 16'd0;
         mot_ff   <= 2'd0;
         wheel_ff <= 2'd0;
      end else begin
         pc_ff    <= pc_in;
         stop_ff  <= stop_in;
         fired_ff <= fired_in;
         idle_ff  <= idle_in;
         mot_ff   <= mot_in;
         wheel_ff <= wheel_in;
      end
   end

   // Datapath operands
   always_comb begin
      cur_setup = setup_ff[wheel_ff];
      cur_speed = speed_ff[wheel_ff];
      mag       = cur_speed[15] ? 17'h10000 - {1'b0, cur_speed} : {1'b0, cur_speed};
      db_rest   = 18'sd32768 - $signed({2'b00, db_ff});
      sum       = $signed({9'd0, db_ff, 28'd0}) + 53'(p2_ff);
      scaled    = {duty_ff, 12'd0} - {12'd0, duty_ff};
   end

   // Duty datapath: magnitude and trim, dead-band scale, offset and clamp, count
   always_ff @(posedge clock) begin
      if (start_wheel) begin
         speed_ff[0] <= req.front_left_speed;
         speed_ff[1] <= req.front_right_speed;
         speed_ff[2] <= req.rear_left_speed;
         speed_ff[3] <= req.rear_right_speed;
      end
      case (cw.op)
         wpcs_pkg::DP_LOAD: begin
            fwd_ff   <= !cur_speed[15] ^ cur_setup[wpcs_pkg::INVERT_BIT];
            small_ff <= (mag < wpcs_pkg::MAG_MIN);
            db_ff    <= cur_setup[wpcs_pkg::DB_LSB +: 16];
            p1_ff    <= 33'(mag) * 33'(cur_setup[wpcs_pkg::TRIM_LSB +: 16]);
         end
         wpcs_pkg::DP_MUL: begin
            p2_ff <= 52'(db_rest) * 52'($signed({1'b0, p1_ff}));
         end
         wpcs_pkg::DP_SUM: begin
            if (small_ff || sum < 0) begin
               duty_ff <= 44'd0;
            end else if (sum > $signed({9'd0, wpcs_pkg::DUTY_ONE})) begin
               duty_ff <= wpcs_pkg::DUTY_ONE;
            end else begin
               duty_ff <= sum[43:0];
            end
         end
         wpcs_pkg::DP_CNT: begin
            cnt_ff  <= scaled[54:43];
            full_ff <= (duty_ff == wpcs_pkg::DUTY_ONE);
         end
         default: ;
      endcase
   end

   // Channel write fields for the current step
   always_comb begin
      wr_on  = 1'b0;
      wr_off = 1'b0;
      wr_cnt = 12'd0;
      case (cw.wr)
         wpcs_pkg::WR_DIR_IN1: begin
            wr_on  = fwd_ff;
            wr_off = !fwd_ff;
         end
         wpcs_pkg::WR_DIR_IN2: begin
            wr_on  = !fwd_ff;
            wr_off = fwd_ff;
         end
         wpcs_pkg::WR_PWM: begin
            wr_on  = full_ff;
            wr_cnt = full_ff ? 12'd0 : cnt_ff;
         end
         default: wr_off = 1'b1;
      endcase
      case (cw.lst)
         wpcs_pkg::LAST_MOTOR: wr_last = (mot_ff == 2'd3);
         wpcs_pkg::LAST_WHEEL: wr_last = !wheels_above;
         default:              wr_last = 1'b0;
      endcase
   end

   // Hold a write beat until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cw.emit && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cw.emit && out_free) begin
         rsp_channel_ff   <= wpcs_pkg::motor_channel(mot_ff, cw.ch);
         rsp_full_on_ff   <= wr_on;
         rsp_full_off_ff  <= wr_off;
         rsp_off_point_ff <= wr_cnt;
         rsp_last_ff      <= wr_last;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.channel   = rsp_channel_ff;
   assign rsp.full_on   = rsp_full_on_ff;
   assign rsp.full_off  = rsp_full_off_ff;
   assign rsp.off_point = rsp_off_point_ff;
   assign rsp.last      = rsp_last_ff;

endmodule
